// ===== src/pcs_pkg.sv =====
// shared types and constants for the presence cleaning sequencer
// no dependencies; used by presence_cleaning_sequencer_unit
package pcs_pkg;

  // elapsed timer width; timers saturate at all ones
  localparam int unsigned TIMER_BITS = 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

  // configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DETECT_MS   = 3'd0;
  localparam logic [2:0] REG_COOLDOWN_MS = 3'd1;
  localparam logic [2:0] REG_STEP_MS     = 3'd2;
  localparam logic [2:0] REG_HOLD_MS     = 3'd3;
  localparam logic [2:0] REG_SWEEP_ANGLE = 3'd4;

  // register reset values
  localparam logic [15:0] DETECT_MS_RST   = 16'd5000;
  localparam logic [15:0] COOLDOWN_MS_RST = 16'd30000;
  localparam logic [7:0]  STEP_MS_RST     = 8'd17;
  localparam logic [15:0] HOLD_MS_RST     = 16'd2000;
  localparam logic [7:0]  SWEEP_ANGLE_RST = 8'd90;

  // servo limit in degrees
  localparam logic [7:0] ANGLE_LIMIT = 8'd180;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DETECT   = 3'd1,
    MODE_OCCUPIED = 3'd2,
    MODE_COOLDOWN = 3'd3,
    MODE_CLEANING = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_HOLD = 2'd2,
    PH_DOWN = 2'd3
  } phase_t;

endpackage

// ===== src/presence_cleaning_sequencer_unit.sv =====
// top level of the presence cleaning sequencer: mode machine, servo sweep,
// visit counter and configuration registers; depends on pcs_pkg
//
// One item is one millisecond tick carrying presence and flush_request. The
// block takes an item in every clock cycle while in_stall is low and shows
// its result in the next cycle: the mode, sweep and counter registers are
// updated at the edge where the item is accepted and drive the result ports
// directly through that single register stage. A result stays on the
// outputs until taken; while out_stall holds a waiting result, in_stall is
// raised and no further item is taken, and the item slot frees in the same
// cycle the result is taken. Configuration lives on an APB-style port at byte
// addresses 0, 4, 8, 12 and 16 (detect, cooldown, step, hold, sweep angle);
// write it only while no item is in flight. There is no clearing pass.
module presence_cleaning_sequencer_unit (
  input  logic                        clk,
  input  logic                        rst,
  // item input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        presence,
  input  logic                        flush_request,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  mode,
  output logic [7:0]                  servo_angle,
  output logic                        servo_active,
  output logic [31:0]                 visit_total,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [pcs_pkg::DATA_W-1:0]  pwdata,
  output logic [pcs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // configuration registers
  logic [15:0] detect_ms;
  logic [15:0] cooldown_ms;
  logic [7:0]  step_ms;
  logic [15:0] hold_ms;
  logic [7:0]  sweep_angle;

  // sequencer state
  pcs_pkg::mode_t                    mode_reg, mode_next;
  logic [pcs_pkg::TIMER_BITS-1:0]    mode_elapsed, mode_elapsed_next;
  logic                              flush_pending, flush_pending_next;
  pcs_pkg::phase_t                   sweep_phase, sweep_phase_next;
  logic [pcs_pkg::TIMER_BITS-1:0]    sweep_elapsed, sweep_elapsed_next;
  logic [7:0]                        angle_reg, angle_next;
  logic [31:0]                       visit_counter, visit_counter_next;

  logic        in_accept;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  // intermediate values between the mode step and the sweep step
  logic                              flush_seen;
  logic                              start_sweep;
  pcs_pkg::phase_t                   phase_mid;
  logic [7:0]                        angle_mid;
  logic [pcs_pkg::TIMER_BITS-1:0]    sweep_el_mid;
  logic [7:0]                        top_angle;
  logic [7:0]                        angle_up;
  logic [7:0]                        angle_down;
  logic                              step_due;

  // ---------------------------------------------------------------------
  // handshake: the state registers are the result register, so an item is
  // taken only when the previous result is gone or leaving this cycle
  // ---------------------------------------------------------------------
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign mode         = mode_reg;
  assign servo_angle  = angle_reg;
  assign servo_active = (sweep_phase != pcs_pkg::PH_IDLE);
  assign visit_total  = visit_counter;

  // ---------------------------------------------------------------------
  // configuration port; unaligned low address bits are ignored
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_ms   <= pcs_pkg::DETECT_MS_RST;
      cooldown_ms <= pcs_pkg::COOLDOWN_MS_RST;
      step_ms     <= pcs_pkg::STEP_MS_RST;
      hold_ms     <= pcs_pkg::HOLD_MS_RST;
      sweep_angle <= pcs_pkg::SWEEP_ANGLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pcs_pkg::REG_DETECT_MS:   detect_ms   <= pwdata[15:0];
        pcs_pkg::REG_COOLDOWN_MS: cooldown_ms <= pwdata[15:0];
        pcs_pkg::REG_STEP_MS:     step_ms     <= pwdata[7:0];
        pcs_pkg::REG_HOLD_MS:     hold_ms     <= pwdata[15:0];
        pcs_pkg::REG_SWEEP_ANGLE: sweep_angle <= pwdata[7:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      pcs_pkg::REG_DETECT_MS:   prdata = {16'd0, detect_ms};
      pcs_pkg::REG_COOLDOWN_MS: prdata = {16'd0, cooldown_ms};
      pcs_pkg::REG_STEP_MS:     prdata = {24'd0, step_ms};
      pcs_pkg::REG_HOLD_MS:     prdata = {16'd0, hold_ms};
      pcs_pkg::REG_SWEEP_ANGLE: prdata = {24'd0, sweep_angle};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // next state for one tick: timers advance first, then the mode step,
  // then the sweep step working on what the mode step left
  // ---------------------------------------------------------------------
  always_comb begin
    flush_seen         = flush_pending | flush_request;
    flush_pending_next = flush_seen;
    mode_next          = mode_reg;
    mode_elapsed_next  = (mode_elapsed == pcs_pkg::TIMER_MAX) ? mode_elapsed
                                                              : mode_elapsed + pcs_pkg::TIMER_ONE;
    sweep_el_mid       = (sweep_elapsed == pcs_pkg::TIMER_MAX) ? sweep_elapsed
                                                               : sweep_elapsed + pcs_pkg::TIMER_ONE;
    visit_counter_next = visit_counter;
    start_sweep        = 1'b0;

    // mode step; a latched or incoming flush wins in idle and cooldown
    if (flush_seen && (mode_reg inside {pcs_pkg::MODE_IDLE, pcs_pkg::MODE_COOLDOWN})) begin
      flush_pending_next = 1'b0;
      mode_next          = pcs_pkg::MODE_CLEANING;
      mode_elapsed_next  = '0;
      start_sweep        = 1'b1;
    end else begin
      case (mode_reg)
        pcs_pkg::MODE_IDLE: begin
          if (presence) begin
            mode_next         = pcs_pkg::MODE_DETECT;
            mode_elapsed_next = '0;
          end
        end
        pcs_pkg::MODE_DETECT: begin
          // losing presence here keeps the timer running, no visit counted
          if (!presence) begin
            mode_next = pcs_pkg::MODE_IDLE;
          end else if (32'(mode_elapsed_next) >= 32'(detect_ms)) begin
            mode_next         = pcs_pkg::MODE_OCCUPIED;
            mode_elapsed_next = '0;
          end
        end
        pcs_pkg::MODE_OCCUPIED: begin
          if (!presence) begin
            visit_counter_next = visit_counter + 32'd1;
            mode_next          = pcs_pkg::MODE_COOLDOWN;
            mode_elapsed_next  = '0;
          end
        end
        pcs_pkg::MODE_COOLDOWN: begin
          if (presence) begin
            mode_next         = pcs_pkg::MODE_OCCUPIED;
            mode_elapsed_next = '0;
          end else if (32'(mode_elapsed_next) >= 32'(cooldown_ms)) begin
            mode_next         = pcs_pkg::MODE_CLEANING;
            mode_elapsed_next = '0;
            start_sweep       = 1'b1;
          end
        end
        pcs_pkg::MODE_CLEANING: begin
          // leave on the tick after the sweep has finished
          if (sweep_phase == pcs_pkg::PH_IDLE) begin
            mode_next         = pcs_pkg::MODE_IDLE;
            mode_elapsed_next = '0;
          end
        end
        default: begin
          mode_next         = pcs_pkg::MODE_IDLE;
          mode_elapsed_next = '0;
        end
      endcase
    end

    // sweep start resets the servo before this tick's sweep step
    phase_mid = sweep_phase;
    angle_mid = angle_reg;
    if (start_sweep) begin
      phase_mid    = pcs_pkg::PH_UP;
      angle_mid    = 8'd0;
      sweep_el_mid = '0;
    end

    top_angle  = (sweep_angle > pcs_pkg::ANGLE_LIMIT) ? pcs_pkg::ANGLE_LIMIT : sweep_angle;
    angle_up   = (angle_mid < pcs_pkg::ANGLE_LIMIT) ? angle_mid + 8'd1 : angle_mid;
    angle_down = (angle_mid != 8'd0) ? angle_mid - 8'd1 : angle_mid;
    step_due   = (32'(sweep_el_mid) >= 32'(step_ms));

    sweep_phase_next   = phase_mid;
    angle_next         = angle_mid;
    sweep_elapsed_next = sweep_el_mid;

    // sweep step: ramp up, hold at the top, ramp down
    case (phase_mid)
      pcs_pkg::PH_UP: begin
        if (step_due) begin
          sweep_elapsed_next = '0;
          angle_next         = angle_up;
          // a zero top angle still rises to one degree before holding
          if (angle_up >= top_angle) begin
            sweep_phase_next = pcs_pkg::PH_HOLD;
          end
        end
      end
      pcs_pkg::PH_HOLD: begin
        if (32'(sweep_el_mid) >= 32'(hold_ms)) begin
          sweep_phase_next   = pcs_pkg::PH_DOWN;
          sweep_elapsed_next = '0;
        end
      end
      pcs_pkg::PH_DOWN: begin
        if (step_due) begin
          sweep_elapsed_next = '0;
          angle_next         = angle_down;
          if (angle_down == 8'd0) begin
            sweep_phase_next = pcs_pkg::PH_IDLE;
          end
        end
      end
      default: ; // idle phase: servo parked
    endcase
  end

  // state advances only when an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= pcs_pkg::MODE_IDLE;
      mode_elapsed  <= '0;
      flush_pending <= 1'b0;
      sweep_phase   <= pcs_pkg::PH_IDLE;
      sweep_elapsed <= '0;
      angle_reg     <= 8'd0;
      visit_counter <= 32'd0;
    end else if (in_accept) begin
      mode_reg      <= mode_next;
      mode_elapsed  <= mode_elapsed_next;
      flush_pending <= flush_pending_next;
      sweep_phase   <= sweep_phase_next;
      sweep_elapsed <= sweep_elapsed_next;
      angle_reg     <= angle_next;
      visit_counter <= visit_counter_next;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // a running sweep only exists in cleaning mode
  assert property (@(posedge clk) disable iff (rst)
    (sweep_phase != pcs_pkg::PH_IDLE) |-> (mode_reg == pcs_pkg::MODE_CLEANING))
    else $error("sweep running outside cleaning mode");

  // the servo is parked whenever no sweep is running
  assert property (@(posedge clk) disable iff (rst)
    (sweep_phase == pcs_pkg::PH_IDLE) |-> (angle_reg == 8'd0))
    else $error("servo angle non-zero with sweep idle");

  // commanded angle never exceeds the servo limit
  assert property (@(posedge clk) disable iff (rst)
    angle_reg <= pcs_pkg::ANGLE_LIMIT)
    else $error("servo angle beyond limit");

  // state and visit count move only with an accepted item
  assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> ($stable(visit_counter) && $stable(mode_reg) && $stable(angle_reg)))
    else $error("state changed without an accepted item");

  // visits are counted only when leaving occupied mode
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (visit_counter_next != visit_counter))
      |-> (mode_reg == pcs_pkg::MODE_OCCUPIED && !presence))
    else $error("visit counted outside end of occupancy");

  // the input is held off only while a result waits
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule
